/* design/sorted_priority_queue_prune_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority queue
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_PRUNE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_PRUNE_DEFINES_SVH

// The condition holds at every clock edge out of reset.
`define SPQP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// The consequence holds in the same cycle as the antecedent.
`define SPQP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequence holds in the cycle after the antecedent.
`define SPQP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/spqp_pkg.sv */
// ----------------------------------------------------------------------------
// spqp_pkg
// Types, constants and helpers shared by the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spqp_pkg;

    localparam int DEPTH         = 16;
    localparam int KEY_FRAC_BITS = 8;

    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 16;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;
    localparam int CNT_W    = $clog2(DEPTH + 1);

    localparam int S_TDATA_W = ((HANDLE_W + KEY_W + KEY_W + 7) / 8) * 8;
    localparam int M_FIELD_W = HANDLE_W + KEY_W + OCC_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PRUNE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE  = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    typedef struct packed {
        logic             ins;
        logic             pop;
        logic             int_mode;
        entry_t           new_entry;
        logic [KEY_W-1:0] thr;
    } cell_ctrl_t;

    localparam logic [KEY_W-1:0] FRAC_MASK = KEY_W'((64'd1 << KEY_FRAC_BITS) - 64'd1);

    function automatic logic [KEY_W-1:0] floor_key(input logic [KEY_W-1:0] key,
                                                   input logic int_mode);
        return int_mode ? (key & ~FRAC_MASK) : key;
    endfunction

endpackage

`default_nettype wire

/* design/spqp_cell.sv */
// ----------------------------------------------------------------------------
// spqp_cell
// One slot of the sorted queue: holds an entry and moves it to or from a
// neighbor on insert and pop.
// ----------------------------------------------------------------------------
`default_nettype none

module spqp_cell (
    input  wire                  clk,
    input  spqp_pkg::cell_ctrl_t ctrl,
    input  wire                  occupied,
    input  wire                  ge_left,
    input  spqp_pkg::entry_t     left_entry,
    input  spqp_pkg::entry_t     right_entry,
    output spqp_pkg::entry_t     entry,
    output logic                 ge,
    output logic                 le
);
    import spqp_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // Keys are sorted descending, so ge is true over a prefix of the row.
    assign ge    = occupied && (entry_reg.key >= ctrl.new_entry.key);
    assign le    = floor_key(entry_reg.key, ctrl.int_mode) <= ctrl.thr;
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (!ge_left)
                entry_next = left_entry;
            else if (!ge)
                entry_next = ctrl.new_entry;
        end
        else if (ctrl.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

/* design/sorted_priority_queue_prune.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue_prune
// Bounded priority queue kept sorted by key, with pop of the head and
// pruning from the tail.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ group: s_tuser carries the request kind (insert,
// pop, prune) and s_tdata the handle, key and threshold. Results leave on the
// m_ group: m_tuser carries the status, m_tdata the handle, key and
// occupancy, and m_tlast marks the final result of a request.
// Insert, pop and the no-op kind give one result each, written into the output
// register; a new request is taken as soon as that register is free, so these
// run at one request per cycle.
// A prune is accepted and latches its threshold. Then, each time the output
// register is free, the tail entry is compared against that threshold and
// removed if not above it, and the entry in front of it is compared too so
// that tlast is known in advance. A prune gives one result per removed entry,
// or one when nothing is removed, and blocks new requests until its last one.
// When the receiver holds m_tready low, the output register keeps its result
// and the block stops taking requests or removing entries until it drains.
// cfg_we/cfg_data write integer_mode; the user must do so only while idle,
// which the block does not enforce. Reset empties the queue and clears
// integer_mode; stored entries stay, as only occupied slots are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_prune (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cfg_we,
    input  wire                            cfg_data,   // integer_mode
    input  wire                            s_tvalid,
    output logic                           s_tready,
    // item_handle[15:0], item_key[47:16], threshold[79:48]
    input  wire [spqp_pkg::S_TDATA_W-1:0]  s_tdata,
    // req_type[1:0]
    input  wire [spqp_pkg::REQ_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    // out_handle[15:0], out_key[47:16], occupancy[52:48], zero pad above
    output logic [spqp_pkg::M_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [spqp_pkg::STATUS_W-1:0]  m_tuser,
    output logic                           m_tlast
);
    import spqp_pkg::*;

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_PRUNE = 1'b1;

    logic                 state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 int_mode_reg;
    logic [KEY_W-1:0]     thr_reg, thr_next;

    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    entry_t               out_entry_reg, out_entry_next;
    logic [CNT_W-1:0]     out_occ_reg, out_occ_next;
    logic                 out_last_reg, out_last_next;

    logic                 out_free;
    logic                 accept;
    logic [HANDLE_W-1:0]  in_handle;
    logic [KEY_W-1:0]     in_key;
    logic [KEY_W-1:0]     in_thr;
    logic                 full;
    logic                 empty;
    logic                 do_ins;
    logic                 do_pop;
    logic                 prune_step;

    cell_ctrl_t           ctrl;
    entry_t               cell_entry [DEPTH];
    logic [DEPTH-1:0]     cell_ge;
    logic [DEPTH-1:0]     cell_le;
    logic [DEPTH-1:0]     occupied;
    logic [DEPTH-1:0]     is_tail;
    logic [DEPTH-1:0]     is_pretail;
    entry_t               tail_entry;
    logic                 tail_le;
    logic                 pre_le;

    assign in_handle = s_tdata[HANDLE_W-1:0];
    assign in_key    = s_tdata[HANDLE_W +: KEY_W];
    assign in_thr    = s_tdata[HANDLE_W + KEY_W +: KEY_W];

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign full   = (cnt_reg == CNT_W'(DEPTH));
    assign empty  = (cnt_reg == '0);
    assign do_ins = accept && (s_tuser == REQ_INSERT) && !full;
    assign do_pop = accept && (s_tuser == REQ_POP) && !empty;

    assign ctrl.ins              = do_ins;
    assign ctrl.pop              = do_pop;
    assign ctrl.int_mode         = int_mode_reg;
    assign ctrl.new_entry.key    = in_key;
    assign ctrl.new_entry.handle = in_handle;
    assign ctrl.thr              = thr_reg;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   ge_l;

            assign occupied[gi]   = CNT_W'(gi) < cnt_reg;
            assign is_tail[gi]    = (CNT_W'(gi + 1) == cnt_reg);
            assign is_pretail[gi] = (CNT_W'(gi + 2) == cnt_reg);

            if (gi == 0)
            begin : g_head
                assign left_e = '0;
                assign ge_l   = 1'b1;
            end
            else
            begin : g_body
                assign left_e = cell_entry[gi-1];
                assign ge_l   = cell_ge[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_end
                assign right_e = '0;
            end
            else
            begin : g_inner
                assign right_e = cell_entry[gi+1];
            end

            spqp_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (occupied[gi]),
                .ge_left    (ge_l),
                .left_entry (left_e),
                .right_entry(right_e),
                .entry      (cell_entry[gi]),
                .ge         (cell_ge[gi]),
                .le         (cell_le[gi])
            );
        end
    endgenerate

    // Tail and the slot in front of it are picked by one-hot selects.
    always_comb
    begin
        tail_entry = '0;
        tail_le    = 1'b0;
        pre_le     = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (is_tail[i])
            begin
                tail_entry = tail_entry | cell_entry[i];
                tail_le    = tail_le | cell_le[i];
            end
            if (is_pretail[i])
                pre_le = pre_le | cell_le[i];
        end
    end

    assign prune_step = (state_reg == S_PRUNE) && out_free && tail_le;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        thr_next        = thr_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_entry_next  = out_entry_reg;
        out_occ_next    = out_occ_reg;
        out_last_next   = out_last_reg;

        if (m_tready)
            out_valid_next = 1'b0;

        if (accept)
        begin
            out_valid_next  = 1'b1;
            out_status_next = ST_DONE;
            out_entry_next  = '0;
            out_occ_next    = cnt_reg;
            out_last_next   = 1'b1;
            case (s_tuser)
                REQ_INSERT:
                begin
                    if (full)
                        out_status_next = ST_FULL;
                    else
                    begin
                        cnt_next     = cnt_reg + 1'b1;
                        out_occ_next = cnt_reg + 1'b1;
                    end
                end
                REQ_POP:
                begin
                    if (empty)
                        out_status_next = ST_EMPTY;
                    else
                    begin
                        cnt_next       = cnt_reg - 1'b1;
                        out_occ_next   = cnt_reg - 1'b1;
                        out_entry_next = cell_entry[0];
                    end
                end
                REQ_PRUNE:
                begin
                    // The result is produced by the prune sequence instead.
                    out_valid_next = 1'b0;
                    thr_next       = in_thr;
                    state_next     = S_PRUNE;
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == S_PRUNE && out_free)
        begin
            out_valid_next = 1'b1;
            if (tail_le)
            begin
                out_status_next = ST_DONE;
                out_entry_next  = tail_entry;
                out_occ_next    = cnt_reg - 1'b1;
                out_last_next   = !pre_le;
                cnt_next        = cnt_reg - 1'b1;
                if (!pre_le)
                    state_next = S_IDLE;
            end
            else
            begin
                out_status_next = ST_NONE;
                out_entry_next  = '0;
                out_occ_next    = cnt_reg;
                out_last_next   = 1'b1;
                state_next      = S_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            int_mode_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                int_mode_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        thr_reg        <= thr_next;
        out_status_reg <= out_status_next;
        out_entry_reg  <= out_entry_next;
        out_occ_reg    <= out_occ_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = M_TDATA_W'({OCC_W'(out_occ_reg), out_entry_reg.key,
                                  out_entry_reg.handle});

`include "sorted_priority_queue_prune_defines.svh"

    `SPQP_ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= CNT_W'(DEPTH), "queue count exceeds depth")
    `SPQP_ASSERT_SAME(a_ready_idle, s_tready, state_reg == S_IDLE, "request taken while pruning")
    `SPQP_ASSERT_NEXT(a_ins_count, do_ins, cnt_reg == $past(cnt_reg) + 1'b1, "insert lost count")
    `SPQP_ASSERT_NEXT(a_prune_count, prune_step, cnt_reg == $past(cnt_reg) - 1'b1,
                      "prune step did not remove tail")
    `SPQP_ASSERT_SAME(a_prune_occupied, prune_step, !empty, "prune removed from empty queue")

endmodule

`default_nettype wire

/* tb/tb_sorted_priority_queue_prune.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue_prune
// Self-checking bench for the sorted priority queue with tail pruning.
// A scoreboard keeps its own sorted copy of the queue and works out every
// result of each accepted request. Results from the block are compared in
// order, field by field. A directed pass covers empty, full, tie and integer
// mode cases. Random passes follow, run under both settings of integer_mode,
// most of them with the sender and the receiver stalling at random.
// ----------------------------------------------------------------------------

module tb_sorted_priority_queue_prune;

    import spqp_pkg::*;

    // The fourth request kind is a no-op that still returns one result.
    localparam logic [REQ_W-1:0] REQ_NOP = 2'd3;

    localparam int CYCLE_LIMIT  = 200_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 30;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key;
        logic [OCC_W-1:0]    occ;
        logic                last;
    } pq_result_t;

    class pq_scoreboard;
        logic [KEY_W-1:0]    keys [DEPTH];
        logic [HANDLE_W-1:0] handles [DEPTH];
        int unsigned         count;
        bit                  int_mode;
        pq_result_t          awaited [$];
        int                  errors;
        int                  requests;
        int                  results;
        int                  pruned;
        int                  dropped;
        int                  empty_pops;
        int                  idle_prunes;

        function new();
            count    = 0;
            int_mode = 1'b0;
        endfunction

        function void queue_result(logic [STATUS_W-1:0] status, logic [HANDLE_W-1:0] handle,
                                   logic [KEY_W-1:0] key, logic last);
            pq_result_t r;
            r.status = status;
            r.handle = handle;
            r.key    = key;
            r.occ    = OCC_W'(count);
            r.last   = last;
            awaited.push_back(r);
        endfunction

        function logic [KEY_W-1:0] compare_key(logic [KEY_W-1:0] key);
            return int_mode ? (key & ~FRAC_MASK) : key;
        endfunction

        // Updates the queue copy for one accepted request and queues its results.
        function void note_request(logic [REQ_W-1:0] req, logic [HANDLE_W-1:0] handle,
                                   logic [KEY_W-1:0] key, logic [KEY_W-1:0] thr);
            int unsigned pos;
            int unsigned i;
            int          n;
            requests++;
            case (req)
                REQ_INSERT:
                begin
                    if (count >= DEPTH)
                    begin
                        dropped++;
                        queue_result(ST_FULL, '0, '0, 1'b1);
                    end
                    else
                    begin
                        pos = 0;
                        while (pos < count && keys[pos] >= key)
                            pos++;
                        for (i = count; i > pos; i--)
                        begin
                            keys[i]    = keys[i-1];
                            handles[i] = handles[i-1];
                        end
                        keys[pos]    = key;
                        handles[pos] = handle;
                        count++;
                        queue_result(ST_DONE, '0, '0, 1'b1);
                    end
                end
                REQ_POP:
                begin
                    if (count == 0)
                    begin
                        empty_pops++;
                        queue_result(ST_EMPTY, '0, '0, 1'b1);
                    end
                    else
                    begin
                        logic [KEY_W-1:0]    head_key;
                        logic [HANDLE_W-1:0] head_handle;
                        head_key    = keys[0];
                        head_handle = handles[0];
                        for (i = 1; i < count; i++)
                        begin
                            keys[i-1]    = keys[i];
                            handles[i-1] = handles[i];
                        end
                        count--;
                        queue_result(ST_DONE, head_handle, head_key, 1'b1);
                    end
                end
                REQ_PRUNE:
                begin
                    n = 0;
                    while (count > 0 && compare_key(keys[count-1]) <= thr)
                    begin
                        count--;
                        queue_result(ST_DONE, handles[count], keys[count], 1'b0);
                        n++;
                    end
                    pruned += n;
                    if (n == 0)
                    begin
                        idle_prunes++;
                        queue_result(ST_NONE, '0, '0, 1'b1);
                    end
                    else
                        awaited[awaited.size()-1].last = 1'b1;
                end
                default:
                    queue_result(ST_DONE, '0, '0, 1'b1);
            endcase
        endfunction

        function void match_result(pq_result_t got);
            pq_result_t want;
            results++;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result: status %0d handle %h key %h occ %0d last %b",
                             $time, got.status, got.handle, got.key, got.occ, got.last);
                return;
            end
            want = awaited.pop_front();
            if (want !== got)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display("%0t: mismatch, expected status %0d handle %h key %h occ %0d last %b",
                             $time, want.status, want.handle, want.key, want.occ, want.last);
                    $display("%0t:           actual status %0d handle %h key %h occ %0d last %b",
                             $time, got.status, got.handle, got.key, got.occ, got.last);
                end
            end
        endfunction
    endclass

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic                 cfg_data = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [REQ_W-1:0]     s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 m_tlast;

    int           tx_idle_pct = 0;
    int           rx_idle_pct = 0;
    int           cycles      = 0;
    pq_scoreboard sb          = new();

    sorted_priority_queue_prune u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_sorted_priority_queue_prune: errors");
            $finish;
        end
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    always @(posedge clk)
    begin : result_monitor
        pq_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status = m_tuser;
            got.handle = m_tdata[HANDLE_W-1:0];
            got.key    = m_tdata[HANDLE_W +: KEY_W];
            got.occ    = m_tdata[HANDLE_W+KEY_W +: OCC_W];
            got.last   = m_tlast;
            sb.match_result(got);
        end
    end

    // Called right after a rising edge; returns at the edge that takes the request.
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [HANDLE_W-1:0] handle,
                                input logic [KEY_W-1:0] key, input logic [KEY_W-1:0] thr);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {thr, key, handle};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(req, handle, key, thr);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= mode;
        @(posedge clk);
        cfg_we      <= 1'b0;
        sb.int_mode  = mode;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        case ($urandom_range(0, 3))
            0: k = $urandom();
            1: k = $urandom_range(0, 32'h3FF);
            // Repeating a stored key exercises the arrival order of ties.
            2: k = (sb.count > 0) ? sb.keys[$urandom_range(0, sb.count - 1)] : $urandom();
            default:
            begin
                k = $urandom();
                k = $urandom_range(0, 1) ? (k & ~FRAC_MASK) : (k | FRAC_MASK);
            end
        endcase
        return k;
    endfunction

    // Thresholds often land near the tail so that prunes remove a few entries.
    function automatic logic [KEY_W-1:0] pick_threshold();
        logic [KEY_W-1:0] t;
        t = $urandom();
        case ($urandom_range(0, 4))
            0: ;
            1, 2:
                if (sb.count > 0)
                    t = sb.keys[$urandom_range(sb.count / 2, sb.count - 1)];
            3:
                if (sb.count > 0)
                    t = (sb.keys[$urandom_range(0, sb.count - 1)] & ~FRAC_MASK) | (t & FRAC_MASK);
            default:
                t = $urandom_range(0, 1) ? '0 : '1;
        endcase
        return t;
    endfunction

    task automatic run_random(input int count, input int insert_pct);
        logic [REQ_W-1:0] req;
        int               roll;
        int               i;
        for (i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < insert_pct)
                req = REQ_INSERT;
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 40)
                    req = REQ_POP;
                else if (roll < 88)
                    req = REQ_PRUNE;
                else
                    req = REQ_NOP;
            end
            send_request(req, HANDLE_W'($urandom()), pick_key(), pick_threshold());
        end
    endtask

    initial
    begin
        int i;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 20;
        rx_idle_pct = 56;
        write_mode(1'b1);

        // Directed pass in integer mode: empty cases, fill to full, ties, then prunes.
        send_request(REQ_POP, '1, '1, '1);
        send_request(REQ_PRUNE, '0, '0, '1);
        send_request(REQ_NOP, HANDLE_W'($urandom()), $urandom(), $urandom());
        send_request(REQ_INSERT, 16'h0000, 32'h0000_0000, '0);
        send_request(REQ_INSERT, 16'hFFFF, 32'hFFFF_FFFF, '1);
        send_request(REQ_INSERT, 16'h0001, 32'h0000_0100, '0);
        send_request(REQ_INSERT, 16'h0002, 32'h0000_0100, '0);
        send_request(REQ_INSERT, 16'h0003, 32'h0000_01FF, '0);
        for (i = 0; i < 11; i++)
            send_request(REQ_INSERT, HANDLE_W'($urandom()),
                         $urandom_range(32'h200, 32'hFFFF_FFFE), $urandom());
        send_request(REQ_INSERT, 16'h1234, 32'h0000_0500, '0);
        send_request(REQ_POP, '0, '0, '0);
        send_request(REQ_PRUNE, '0, '0, 32'h0000_0000);
        send_request(REQ_PRUNE, '0, '0, 32'h0000_00FF);
        // Floored, 0x1FF compares equal to 0x100, so it goes with the two ties.
        send_request(REQ_PRUNE, '0, '0, 32'h0000_0100);
        send_request(REQ_PRUNE, '0, '0, 32'hFFFF_FFFF);

        write_mode(1'b0);
        run_random(40, 60);

        tx_idle_pct = 56;
        rx_idle_pct = 20;
        write_mode(1'b1);
        run_random(20, 45);
        wait_drained();
        run_random(20, 45);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_mode(1'b0);
        run_random(45, 50);

        wait_drained();
        repeat (20) @(posedge clk);
        if (sb.awaited.size() != 0)
            sb.errors++;

        $display("Covered %0d requests and %0d results under both key compare modes.",
                 sb.requests, sb.results);
        $display("Pruned %0d entries; %0d full inserts, %0d empty pops, %0d idle prunes.",
                 sb.pruned, sb.dropped, sb.empty_pops, sb.idle_prunes);
        if (sb.errors == 0)
            $display("tb_sorted_priority_queue_prune: clean");
        else
            $display("tb_sorted_priority_queue_prune: errors");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/spqp_pkg.sv
design/spqp_cell.sv
design/sorted_priority_queue_prune.sv
tb/tb_sorted_priority_queue_prune.sv
